FILE: hdl/sspb_pkg.sv
// Shared types and constants for the sliced sample playback block.
// Used by every module in this folder but sspb_div; depends on nothing else.
package sspb_pkg;

    localparam int MAX_FRAMES_DEF = 65536;
    localparam int MAX_SLICES_DEF = 128;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int SMP_BITS       = 16;
    localparam int OUT_BITS       = 20;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 17;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_MODE    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLICE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTH_OUTS    = 3'd6;

    localparam logic [1:0] TRIG_ONESHOT = 2'd0;
    localparam logic [1:0] TRIG_GATE    = 2'd1;
    localparam logic [1:0] TRIG_SLICE   = 2'd2;

    localparam logic [1:0] READ_FWD = 2'd0;
    localparam logic [1:0] READ_BWD = 2'd1;
    localparam logic [1:0] READ_RPT = 2'd2;

    localparam logic       OP_TICK = 1'b0;
    localparam logic       OP_LOAD = 1'b1;

    typedef struct packed {
        logic                       op;
        logic                       gate_level;
        logic                       position_present;
        logic [9:0]                 position_fraction;
        logic                       reset_level;
        logic [15:0]                load_address;
        logic signed [SMP_BITS-1:0] load_left;
        logic signed [SMP_BITS-1:0] load_right;
    } t_in;

    typedef struct packed {
        logic                       playing;
        logic signed [OUT_BITS-1:0] out_left;
        logic signed [OUT_BITS-1:0] out_right;
    } t_out;

    typedef struct packed {
        logic [1:0]  trigger_mode;
        logic [1:0]  read_mode;
        logic [7:0]  slice_count;
        logic [11:0] speed_q4_8;
        logic        stereo_sample;
        logic [16:0] sample_length;
        logic        both_outputs_used;
    } t_cfg;

    // Commands from the controller to the datapath, one cycle each.
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic calc;
        logic div_start;
        logic div_mod;
        logic sl_latch;
        logic cs_pick;
        logic mul;
        logic pos;
        logic rd;
        logic adv;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic slice_rise;
        logic present;
        logic div_done;
    } t_status;

endpackage

FILE: hdl/sspb_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for slice length and slice wrap; depends on nothing.
module sspb_div #(
    parameter int DW = 17,
    parameter int NW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [NW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   rem_sh;
    logic [NW:0]   rem_sub;
    logic          qbit;

    always_comb begin
        rem_sh  = {r_rem, r_q[DW-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        qbit    = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], qbit};
                r_rem <= qbit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

FILE: hdl/sspb_datapath.sv
// Datapath: sample store, playback state, position arithmetic and outputs.
// Depends on sspb_pkg and sspb_div; driven by commands from sspb_ctrl.
module sspb_datapath #(
    parameter int MAX_FRAMES = 65536,
    parameter int MAX_SLICES = 128,
    parameter int FRAC_BITS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sspb_pkg::t_cfg    i_cfg,
    input  sspb_pkg::t_in     i_in,
    input  sspb_pkg::t_cmd    i_cmd,
    output sspb_pkg::t_status o_status,
    output sspb_pkg::t_out    o_out
);
    import sspb_pkg::*;

    localparam int AW  = $clog2(MAX_FRAMES);
    localparam int LW  = AW + 1;
    localparam int NW  = $clog2(MAX_SLICES + 1);
    localparam int CSW = NW + 1;
    localparam int DW  = (LW > CSW) ? LW : CSW;
    localparam int PW  = LW + FRAC_BITS + 2;
    localparam int AB  = CSW + LW + 1;
    localparam int WW  = AB + FRAC_BITS + 1;

    logic [2*SMP_BITS-1:0] r_mem [MAX_FRAMES];

    t_in                   r_in;
    logic [LW-1:0]         r_len, r_p, r_sl;
    logic [NW-1:0]         r_n, r_sp;
    logic [PW-1:0]         r_step;
    logic                  r_rise, r_gate_prev, r_rst_prev, r_flag;
    logic signed [CSW-1:0] r_cs;
    logic signed [PW-1:0]  r_pos;
    logic signed [AB-1:0]  r_a, r_b;
    logic [2*SMP_BITS-1:0] r_rd;
    logic signed [OUT_BITS-1:0] r_hl, r_hr;
    t_out                  r_out;

    logic [AW+15:0]        ld_ext;
    logic [31:0]           len32, sc32, spd32;
    logic [LW-1:0]         len_c;
    logic [NW-1:0]         n_c;
    logic [PW-1:0]         step_c;
    logic [9:0]            frac_eff;
    logic [LW+9:0]         pprod;
    logic [NW+9:0]         sprod;
    logic                  rise_c;
    logic signed [CSW-1:0] cs_inc;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_quot;
    logic [NW-1:0]         div_rem;
    logic                  div_done;
    logic signed [AB-1:0]  a_c, b_c, sl_s, len_s, bm1;
    logic [LW-1:0]         a_cl, bm1_cl, lenm1;
    logic signed [PW-1:0]  lenf;
    logic signed [PW-1:0]  pos_trig;
    logic                  flag_trig;
    logic                  active;
    logic [AW-1:0]         rd_idx;
    logic signed [OUT_BITS-1:0] smp_l, smp_r, smp_sum, x5_l, x5_r, x5_sum;
    logic signed [WW-1:0]  posw, npos, hi, lo, lenfw, bw;
    logic signed [PW-1:0]  pos_adv;
    logic                  flag_adv;

    function automatic logic signed [PW-1:0] to_pos(input logic [LW-1:0] v);
        to_pos = $signed(PW'(v) << FRAC_BITS);
    endfunction

    function automatic logic [LW-1:0] clamp_len(input logic signed [AB-1:0] v,
                                                input logic signed [AB-1:0] lim);
        if (v < 0) clamp_len = '0;
        else if (v > lim) clamp_len = lim[LW-1:0];
        else clamp_len = v[LW-1:0];
    endfunction

    sspb_div #(.DW(DW), .NW(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        ld_ext   = (AW + 16)'(r_in.load_address);
        len32    = 32'(i_cfg.sample_length);
        len_c    = LW'((len32 > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : len32);
        sc32     = 32'(i_cfg.slice_count);
        n_c      = NW'((sc32 < 32'd1) ? 32'd1 :
                       (sc32 > 32'(MAX_SLICES)) ? 32'(MAX_SLICES) : sc32);
        spd32    = 32'(i_cfg.speed_q4_8);
        spd32    = (spd32 < 32'd51) ? 32'd51 : (spd32 > 32'd2560) ? 32'd2560 : spd32;
        step_c   = PW'((spd32 << FRAC_BITS) >> 8);
        frac_eff = r_in.position_present ? r_in.position_fraction : 10'd0;
        pprod    = (LW + 10)'(frac_eff) * (LW + 10)'(len_c);
        sprod    = (NW + 10)'(r_in.position_fraction) * (NW + 10)'(n_c);
        rise_c   = r_in.gate_level && !r_gate_prev;

        cs_inc       = r_cs + CSW'(1);
        div_dividend = i_cmd.div_mod ? DW'($unsigned(cs_inc)) : DW'(r_len);

        sl_s  = $signed(AB'(r_sl));
        len_s = $signed(AB'(r_len));
        a_c   = AB'(r_cs) * sl_s;
        b_c   = AB'(cs_inc) * sl_s;
        bm1   = r_b - AB'(1);
        a_cl  = clamp_len(r_a, len_s);
        bm1_cl = clamp_len(bm1, len_s);
        lenm1 = (r_len == '0) ? '0 : r_len - LW'(1);
        lenf  = to_pos(r_len);

        // Trigger handling: start position and play flag.
        flag_trig = r_flag;
        pos_trig  = r_pos;
        case (i_cfg.trigger_mode)
            TRIG_ONESHOT: begin
                if (r_rise) begin
                    flag_trig = 1'b1;
                    if (r_in.position_present) pos_trig = to_pos(r_p);
                    else if (i_cfg.read_mode != READ_BWD) pos_trig = '0;
                    else pos_trig = to_pos(lenm1);
                end
            end
            TRIG_GATE: begin
                flag_trig = r_in.gate_level;
                pos_trig  = to_pos(r_p);
            end
            TRIG_SLICE: begin
                if (r_rise) begin
                    flag_trig = 1'b1;
                    pos_trig  = (i_cfg.read_mode != READ_BWD) ? to_pos(a_cl)
                                                              : to_pos(bm1_cl);
                end
            end
            default: begin
                flag_trig = r_flag;
            end
        endcase

        // Playback step.
        active  = r_flag && !r_pos[PW-1] && (r_pos < lenf);
        rd_idx  = r_pos[FRAC_BITS+AW-1:FRAC_BITS];
        smp_l   = OUT_BITS'($signed(r_rd[2*SMP_BITS-1:SMP_BITS]));
        smp_r   = OUT_BITS'($signed(r_rd[SMP_BITS-1:0]));
        smp_sum = smp_l + smp_r;
        x5_l    = (smp_l <<< 2) + smp_l;
        x5_r    = (smp_r <<< 2) + smp_r;
        x5_sum  = (smp_sum <<< 2) + smp_sum;

        posw  = WW'(r_pos);
        lenfw = WW'(lenf);
        npos  = (i_cfg.read_mode != READ_BWD) ? posw + WW'($signed({1'b0, r_step}))
                                              : posw - WW'($signed({1'b0, r_step}));
        bw    = WW'(r_b) <<< FRAC_BITS;
        if (i_cfg.trigger_mode == TRIG_SLICE) begin
            hi = (bw > lenfw) ? lenfw : bw;
            lo = (r_a < 0) ? '0 : (WW'(r_a) <<< FRAC_BITS);
        end else begin
            hi = lenfw;
            lo = '0;
        end

        pos_adv  = r_pos;
        flag_adv = r_flag;
        if (active) begin
            if (i_cfg.trigger_mode == TRIG_ONESHOT || i_cfg.trigger_mode == TRIG_SLICE) begin
                pos_adv = PW'(npos);
                if (i_cfg.read_mode == READ_FWD && npos >= hi) begin
                    flag_adv = 1'b0;
                end else if (i_cfg.read_mode == READ_BWD && npos <= lo) begin
                    flag_adv = 1'b0;
                end else if (i_cfg.read_mode == READ_RPT && npos >= hi) begin
                    pos_adv = (i_cfg.trigger_mode == TRIG_ONESHOT) ? to_pos(r_p)
                                                                   : to_pos(a_cl);
                end
            end
        end else if (r_pos == lenf) begin
            flag_adv = 1'b0;
        end
    end

    // Sample store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (ld_ext < (AW + 16)'(MAX_FRAMES))) begin
            r_mem[ld_ext[AW-1:0]] <= {r_in.load_left, r_in.load_right};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_idx];
        end
    end

    // Payload and per-item working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in;
        if (i_cmd.calc) begin
            r_len  <= len_c;
            r_n    <= n_c;
            r_step <= step_c;
            r_p    <= pprod[LW+9:10];
            r_sp   <= sprod[NW+9:10];
        end
        if (i_cmd.sl_latch) begin
            r_sl <= (r_len == '0) ? '0 : (div_quot == '0) ? LW'(1) : div_quot[LW-1:0];
        end
        if (i_cmd.mul) begin
            r_a <= a_c;
            r_b <= b_c;
        end
        if (i_cmd.pos && r_in.reset_level && !r_rst_prev) begin
            r_a <= '0;
            r_b <= sl_s;
        end
        if (i_cmd.out_load) r_out <= '{playing: r_flag, out_left: r_hl, out_right: r_hr};
    end

    // Playback state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 1'b0;
            r_pos       <= '0;
            r_cs        <= '1;
            r_gate_prev <= 1'b0;
            r_rst_prev  <= 1'b0;
            r_rise      <= 1'b0;
            r_hl        <= '0;
            r_hr        <= '0;
        end else begin
            if (i_cmd.calc) begin
                if (i_cfg.trigger_mode == TRIG_ONESHOT || i_cfg.trigger_mode == TRIG_SLICE) begin
                    r_rise      <= rise_c;
                    r_gate_prev <= r_in.gate_level;
                end else begin
                    r_rise <= 1'b0;
                end
            end
            if (i_cmd.cs_pick) begin
                r_cs <= r_in.position_present ? $signed({1'b0, r_sp})
                                              : $signed({1'b0, div_rem});
            end
            if (i_cmd.pos) begin
                r_flag     <= flag_trig;
                r_rst_prev <= r_in.reset_level;
                if (r_in.reset_level && !r_rst_prev) begin
                    r_cs  <= '0;
                    r_pos <= '0;
                end else begin
                    r_pos <= pos_trig;
                end
            end
            if (i_cmd.adv) begin
                r_flag <= flag_adv;
                r_pos  <= pos_adv;
                if (active) begin
                    if (!i_cfg.stereo_sample) begin
                        r_hl <= x5_l;
                        r_hr <= x5_l;
                    end else if (i_cfg.both_outputs_used) begin
                        r_hl <= x5_l;
                        r_hr <= x5_r;
                    end else begin
                        r_hl <= x5_sum;
                        r_hr <= x5_sum;
                    end
                end
            end
        end
    end

    assign o_status = '{is_load: (r_in.op == OP_LOAD),
                        slice_rise: r_rise && (i_cfg.trigger_mode == TRIG_SLICE),
                        present: r_in.position_present,
                        div_done: div_done};
    assign o_out = r_out;
endmodule

FILE: hdl/sspb_ctrl.sv
// Controller: sequences one item through the datapath and runs the handshakes.
// Depends on sspb_pkg for the command and status structs.
module sspb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sspb_pkg::t_status i_status,
    output sspb_pkg::t_cmd    o_cmd
);
    import sspb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK, ST_DS1, ST_DW1, ST_DS2, ST_DW2, ST_PICK,
        ST_MUL, ST_POS, ST_RD, ST_ADV, ST_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    t_state n_state;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_status.is_load) begin
                    cmd.load_wr = 1'b1;
                    n_state     = ST_FIN;
                end else begin
                    cmd.calc = 1'b1;
                    n_state  = ST_DS1;
                end
            end
            ST_DS1: begin
                cmd.div_start = 1'b1;
                n_state       = ST_DW1;
            end
            ST_DW1: begin
                if (i_status.div_done) begin
                    cmd.sl_latch = 1'b1;
                    if (!i_status.slice_rise) n_state = ST_MUL;
                    else if (i_status.present) n_state = ST_PICK;
                    else n_state = ST_DS2;
                end
            end
            ST_DS2: begin
                cmd.div_start = 1'b1;
                cmd.div_mod   = 1'b1;
                n_state       = ST_DW2;
            end
            ST_DW2: begin
                if (i_status.div_done) n_state = ST_PICK;
            end
            ST_PICK: begin
                cmd.cs_pick = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                n_state = ST_POS;
            end
            ST_POS: begin
                cmd.pos = 1'b1;
                n_state = ST_RD;
            end
            ST_RD: begin
                cmd.rd  = 1'b1;
                n_state = ST_ADV;
            end
            ST_ADV: begin
                cmd.adv = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

FILE: hdl/sliced_sample_playback.sv
// Top level of the sliced stereo sample player: configuration registers,
// controller and datapath. Depends on sspb_pkg, sspb_ctrl and sspb_datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready o_out_data (t_out)
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A load is captured, written to the store and put in the output register. A
// tick runs the iterative divider for the slice length, then the multiply,
// position, read, advance and output steps; a slice trigger adds a slice pick,
// and without a position input a second divider pass to wrap the slice number.
// Reset is synchronous and active low and needs no clearing pass.
// A new item is taken while a finished result still waits in the output
// register; the last step of the next item waits only if that result is
// still not taken.
module sliced_sample_playback #(
    parameter int MAX_FRAMES = sspb_pkg::MAX_FRAMES_DEF,
    parameter int MAX_SLICES = sspb_pkg::MAX_SLICES_DEF,
    parameter int FRAC_BITS  = sspb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sspb_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sspb_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [sspb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sspb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import sspb_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    // Configuration registers. Writes to an index outside the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{trigger_mode: TRIG_ONESHOT, read_mode: READ_FWD,
                       slice_count: 8'd1, speed_q4_8: 12'd256, stereo_sample: 1'b0,
                       sample_length: 17'd0, both_outputs_used: 1'b1};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_MODE: r_cfg.trigger_mode      <= i_cfg_data[1:0];
                CFG_READ_MODE:    r_cfg.read_mode         <= i_cfg_data[1:0];
                CFG_SLICE_COUNT:  r_cfg.slice_count       <= i_cfg_data[7:0];
                CFG_SPEED:        r_cfg.speed_q4_8        <= i_cfg_data[11:0];
                CFG_STEREO:       r_cfg.stereo_sample     <= i_cfg_data[0];
                CFG_LENGTH:       r_cfg.sample_length     <= i_cfg_data[16:0];
                CFG_BOTH_OUTS:    r_cfg.both_outputs_used <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The controller walks each item through the datapath steps.
    sspb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the sample store and all playback state.
    sspb_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_SLICES (MAX_SLICES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out_data)
    );
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the sliced sample playback block.
// Depends on sspb_pkg and the RTL of sliced_sample_playback; needs nothing else.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sspb_pkg::*;

    // The scoreboard holds its own copy of the player: the sample store, the
    // playback state and the registers. Each accepted item advances that copy
    // and queues the frame it should produce; each result is checked against
    // the oldest queued frame.
    class playback_scoreboard;
        logic signed [15:0] left_mem[65536];
        logic signed [15:0] right_mem[65536];
        bit      written[65536];
        bit      playing;
        longint  position;
        longint  slice_no;
        bit      gate_q;
        bit      rst_q;
        longint  held_l;
        longint  held_r;
        t_cfg    cfg;
        t_out    frames_due[$];
        int      errors;

        function new();
            playing = 0;
            position = 0;
            slice_no = -1;
            gate_q = 0;
            rst_q = 0;
            held_l = 0;
            held_r = 0;
            errors = 0;
            cfg = '0;
            cfg.slice_count = 8'd1;
            cfg.speed_q4_8 = 12'd256;
            cfg.both_outputs_used = 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                CFG_TRIGGER_MODE: cfg.trigger_mode = d[1:0];
                CFG_READ_MODE:    cfg.read_mode = d[1:0];
                CFG_SLICE_COUNT:  cfg.slice_count = d[7:0];
                CFG_SPEED:        cfg.speed_q4_8 = d[11:0];
                CFG_STEREO:       cfg.stereo_sample = d[0];
                CFG_LENGTH:       cfg.sample_length = d[16:0];
                CFG_BOTH_OUTS:    cfg.both_outputs_used = d[0];
                default: ;
            endcase
        endfunction

        function longint frame_pick(bit present, logic [9:0] frac, longint len);
            longint p;
            p = ((present ? longint'(frac) : 64'sd0) * len) >>> 10;
            if (p > len - 1) p = len - 1;
            if (p < 0) p = 0;
            return p;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        // Runs one item. With commit low the state is left untouched, which
        // lets the stimulus find out which frame a tick would read.
        function t_out advance(t_in it, bit commit, output int rd_frame);
            bit     pl, gq, rq, rise;
            longint pos, cs, hl, hr, len, n, stp, sl, lenf, lo, hi, l, r;
            t_out   res;
            pl = playing; pos = position; cs = slice_no;
            gq = gate_q; rq = rst_q; hl = held_l; hr = held_r;
            rd_frame = -1;
            rise = 0;
            if (it.op == OP_LOAD) begin
                if (commit) begin
                    left_mem[it.load_address] = it.load_left;
                    right_mem[it.load_address] = it.load_right;
                    written[it.load_address] = 1;
                end
            end else begin
                len = (cfg.sample_length > 65536) ? 65536 : cfg.sample_length;
                n = clip(cfg.slice_count, 1, 128);
                stp = clip(cfg.speed_q4_8, 51, 2560);
                sl = len / n;
                lenf = len * 256;
                if (sl < 1) sl = 1;
                if (sl > len) sl = len;
                if (cfg.trigger_mode == TRIG_ONESHOT || cfg.trigger_mode == TRIG_SLICE) begin
                    rise = it.gate_level && !gq;
                    gq = it.gate_level;
                end
                if (cfg.trigger_mode == TRIG_ONESHOT && rise) begin
                    pl = 1;
                    if (it.position_present)
                        pos = frame_pick(1, it.position_fraction, len) * 256;
                    else if (cfg.read_mode != READ_BWD)
                        pos = 0;
                    else
                        pos = (len > 0 ? len - 1 : 0) * 256;
                end else if (cfg.trigger_mode == TRIG_GATE) begin
                    pl = it.gate_level;
                    pos = frame_pick(it.position_present, it.position_fraction, len) * 256;
                end else if (cfg.trigger_mode == TRIG_SLICE && rise) begin
                    pl = 1;
                    if (it.position_present)
                        cs = (longint'(it.position_fraction) * n) >>> 10;
                    else
                        cs = (cs + 1) % n;
                    if (cfg.read_mode != READ_BWD)
                        pos = clip(cs * sl, 0, len) * 256;
                    else
                        pos = clip((cs + 1) * sl - 1, 0, len) * 256;
                end
                if (it.reset_level && !rq) begin
                    cs = 0;
                    pos = 0;
                end
                rq = it.reset_level;
                if (pl && pos >= 0 && pos < lenf) begin
                    rd_frame = int'(pos >>> 8);
                    l = left_mem[rd_frame];
                    r = right_mem[rd_frame];
                    if (!cfg.stereo_sample) begin
                        hl = 5 * l; hr = 5 * l;
                    end else if (cfg.both_outputs_used) begin
                        hl = 5 * l; hr = 5 * r;
                    end else begin
                        hl = 5 * (l + r); hr = 5 * (l + r);
                    end
                    if (cfg.trigger_mode == TRIG_ONESHOT || cfg.trigger_mode == TRIG_SLICE) begin
                        lo = 0;
                        hi = lenf;
                        if (cfg.read_mode != READ_BWD) pos = pos + stp;
                        else pos = pos - stp;
                        if (cfg.trigger_mode == TRIG_SLICE) begin
                            lo = cs * sl * 256;
                            hi = (cs + 1) * sl * 256;
                            if (hi > lenf) hi = lenf;
                            if (lo < 0) lo = 0;
                        end
                        if (cfg.read_mode == READ_FWD && pos >= hi)
                            pl = 0;
                        else if (cfg.read_mode == READ_BWD && pos <= lo)
                            pl = 0;
                        else if (cfg.read_mode == READ_RPT && pos >= hi) begin
                            if (cfg.trigger_mode == TRIG_ONESHOT)
                                pos = frame_pick(it.position_present,
                                                 it.position_fraction, len) * 256;
                            else
                                pos = clip(cs * sl, 0, len) * 256;
                        end
                    end
                end else if (pos == lenf) begin
                    pl = 0;
                end
            end
            if (commit) begin
                playing = pl; position = pos; slice_no = cs;
                gate_q = gq; rst_q = rq; held_l = hl; held_r = hr;
            end
            res.playing = pl;
            res.out_left = hl[OUT_BITS-1:0];
            res.out_right = hr[OUT_BITS-1:0];
            return res;
        endfunction

        // Frame that a tick would read from a never-loaded store entry, or -1.
        function int unloaded_read(t_in it);
            int   f;
            t_out unused;
            unused = advance(it, 0, f);
            if (f >= 0 && !written[f]) return f;
            return -1;
        endfunction

        function void note_input(t_in it);
            int   f;
            t_out due;
            due = advance(it, 1, f);
            frames_due = {frames_due, due};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.playing !== want.playing) begin
                $display("%0t: playing expected %0b actual %0b", $time,
                         want.playing, got.playing);
                errors++;
            end
            if (got.out_left !== want.out_left) begin
                $display("%0t: out_left expected %0d actual %0d", $time,
                         want.out_left, got.out_left);
                errors++;
            end
            if (got.out_right !== want.out_right) begin
                $display("%0t: out_right expected %0d actual %0d", $time,
                         want.out_right, got.out_right);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_in_valid = 0;
    logic                      o_in_ready;
    t_in                       i_in_data = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 0;
    t_out                      o_out_data;
    logic                      i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    // A tick can take two divider passes; this comfortably covers the worst
    // case at the default sizes.
    localparam int SETTLE_CYCLES = 120;

    playback_scoreboard sb = new();
    bit  gate_drv;       // gate level last offered, so edges come at will
    bit  sender_busy_free; // set while the sender runs with no gaps
    int  cycle_no;

    sliced_sample_playback DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Every accepted result is checked at the edge where the transfer happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // Receiver: ready drops in about 28 percent of cycles, never drops in one
    // stretch, and is held low through another so the block fills up and
    // stalls its input while the sender keeps offering items.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 3000 && cycle_no < 5000)
            i_out_ready <= 1'b1;
        else if (cycle_no >= 7000 && cycle_no < 7400)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= 28);
    end

    // Offers one item and waits for its transfer, with a random gap ahead of
    // it unless the sender is in its gap-free stretch.
    task automatic send(t_in it);
        if (!sender_busy_free && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task automatic send_load(int addr, logic [15:0] l, logic [15:0] r);
        t_in         it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        it.op = OP_LOAD;
        it.load_address = addr[15:0];
        it.load_left = l;
        it.load_right = r;
        send(it);
    endtask

    // Sends a tick, first filling any store entry it would read that was
    // never loaded, since such a read has no defined result.
    task automatic send_tick(t_in it);
        int f;
        it.op = OP_TICK;
        f = sb.unloaded_read(it);
        if (f >= 0)
            send_load(f, 16'($urandom), 16'($urandom));
        send(it);
    endtask

    function automatic t_in random_tick();
        t_in         it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        if ($urandom_range(99) < 35) gate_drv = !gate_drv;
        it.gate_level = gate_drv;
        it.reset_level = ($urandom_range(99) < 6);
        it.op = OP_TICK;
        return it;
    endfunction

    // Waits until every expected result has come, then lets the block
    // settle so that registers can be written while it is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, int d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        sb.write_reg(idx, d[CFG_DATA_BITS-1:0]);
    endtask

    task automatic configure(int trig, int rdm, int slices, int spd, int st, int len,
                             int both);
        set_reg(CFG_TRIGGER_MODE, trig);
        set_reg(CFG_READ_MODE, rdm);
        set_reg(CFG_SLICE_COUNT, slices);
        set_reg(CFG_SPEED, spd);
        set_reg(CFG_STEREO, st);
        set_reg(CFG_LENGTH, len);
        set_reg(CFG_BOTH_OUTS, both);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in it;
        int  len;
        i_rst_n = 0;
        gate_drv = 0;
        sender_busy_free = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With nothing loaded and the reset configuration, a
        // trigger starts and stops at once and no sample is output.
        it = '0;
        it.gate_level = 1;
        send(it);
        it.gate_level = 0;
        send(it);
        drain();

        // A four-frame stereo sample with the sample extremes, plus a load
        // to the top address.
        configure(TRIG_ONESHOT, READ_FWD, 1, 256, 1, 4, 1);
        send_load(0, 16'sh8000, 16'sh7fff);
        send_load(1, 16'sh7fff, 16'sh8000);
        send_load(2, 16'hffff, 16'h0000);
        send_load(3, 16'h0001, 16'hffff);
        send_load(65535, 16'h5a5a, 16'ha5a5);
        it = '0;
        it.gate_level = 1;
        repeat (5) send_tick(it);
        // A position reset edge while stopped, then a trigger with the
        // position input at its top value.
        it.reset_level = 1;
        send_tick(it);
        it.gate_level = 0;
        it.reset_level = 0;
        send_tick(it);
        it.gate_level = 1;
        it.position_present = 1;
        it.position_fraction = 10'h3ff;
        send_tick(it);
        drain();

        // Summed stereo, backward, slowest speed, gate mode following position.
        configure(TRIG_GATE, READ_BWD, 128, 51, 1, 4, 0);
        it.position_fraction = 10'h200;
        send_tick(it);
        it.gate_level = 0;
        send_tick(it);
        drain();

        // Random phases cover every trigger and read mode pairing; the first
        // two use the extremes of the registers.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 0)
                configure(TRIG_ONESHOT, READ_FWD, 128, 2560, 1, 65536, 1);
            else if (ph == 1)
                configure(TRIG_GATE, READ_FWD, 1, 51, 0, 1, 0);
            else begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 48);
                configure(ph % 3, (ph / 3) % 3, $urandom_range(1, 128),
                          $urandom_range(51, 2560), $urandom_range(1),
                          len, $urandom_range(1));
            end
            sender_busy_free = (ph == 4);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(99) < 10)
                    send_load($urandom_range(65535), 16'($urandom), 16'($urandom));
                else
                    send_tick(random_tick());
            end
            // Once mid-phase the sender holds back until everything is out.
            if (ph == 5) begin
                i_in_valid <= 1'b0;
                while (sb.frames_due.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
                for (int k = 0; k < 20; k++) send_tick(random_tick());
            end
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sspb_pkg.sv
hdl/sspb_div.sv
hdl/sspb_datapath.sv
hdl/sspb_ctrl.sv
hdl/sliced_sample_playback.sv
verif/testbench.sv
